// ----- design/bts_pkg.sv -----
package bts_pkg;

   // Table geometry and fixed-point format.
   localparam int TABLE_ENTRIES = 64;
   localparam int INDEX_WIDTH   = $clog2(TABLE_ENTRIES);
   localparam int COUNT_WIDTH   = INDEX_WIDTH + 1;
   localparam int FRACTION_BITS = 48;
   localparam int VALUE_WIDTH   = FRACTION_BITS + 1;
   localparam int SAMPLE_WIDTH  = 16;
   localparam int WORD_WIDTH    = 64;
   localparam int HALF_WIDTH    = WORD_WIDTH / 2;
   localparam int CSR_IDX_WIDTH = 2;

   // Generator constants.
   localparam logic [WORD_WIDTH-1:0] SEED_XOR = 64'h38EC_AC5F_B325_1641;
   localparam logic [WORD_WIDTH-1:0] OUT_MULT = 64'd2685821657736338717;
   localparam int SHIFT_A = 21;
   localparam int SHIFT_B = 35;
   localparam int SHIFT_C = 4;

   localparam logic [SAMPLE_WIDTH-1:0] TRIALS_RESET = 16'd2000;

   // Item commands.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SEED    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TRIALS  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REFLECT = 2'd2;

   typedef struct packed {
      logic                   cmd;
      logic [INDEX_WIDTH-1:0] entry_index;
      logic [VALUE_WIDTH-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic [WORD_WIDTH-1:0]   random_word;
   } rsp_type;

   // Operand selection of the shared 32x32 multiplier.
   typedef enum logic [1:0] {
      MUL_LL = 2'd0,
      MUL_HL = 2'd1,
      MUL_LH = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        seed_init;
      logic        seed_load;
      logic        rng_step;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        state_from_prod;
      logic        word_from_prod;
      logic        search_init;
      logic        search_cmp;
      logic        rsp_load;
      logic        tbl_write;
      logic        cfg_write;
   } dp_cmd_type;

   typedef struct packed {
      logic search_last;
   } dp_status_type;

endpackage

// ----- design/bts_datapath.sv -----
module bts_datapath
   import bts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  req_type                  req_data,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]    csr_data,
   output dp_status_type            status,
   output rsp_type                  rsp_data
);

   logic [WORD_WIDTH-1:0]   state_ff, state_in;
   logic [WORD_WIDTH-1:0]   prod_ff, prod_in;
   logic [WORD_WIDTH-1:0]   acc_ff, acc_in;
   logic [WORD_WIDTH-1:0]   word_ff, word_in;
   logic [COUNT_WIDTH-1:0]  base_ff, base_in;
   logic [COUNT_WIDTH-1:0]  half_ff, half_in;
   logic [VALUE_WIDTH-1:0]  rd_data_ff;
   logic [SAMPLE_WIDTH-1:0] trials_ff, trials_in;
   logic                    reflect_ff, reflect_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [VALUE_WIDTH-1:0]  cdf_mem [TABLE_ENTRIES];

   logic [WORD_WIDTH-1:0]   xs1, xs2, xs3;
   logic [HALF_WIDTH-1:0]   mul_a, mul_b;
   logic [WORD_WIDTH-1:0]   acc_sum;
   logic [COUNT_WIDTH-1:0]  probe;
   logic [INDEX_WIDTH-1:0]  rd_addr;
   logic [VALUE_WIDTH-1:0]  frac;
   logic                    go_upper;
   logic                    extra_probe;
   logic [SAMPLE_WIDTH-1:0] count_ext;

   // One xorshift step of the generator state.
   always_comb begin
      xs1 = state_ff ^ (state_ff >> SHIFT_A);
      xs2 = xs1 ^ (xs1 << SHIFT_B);
      xs3 = xs2 ^ (xs2 >> SHIFT_C);
   end

   // Shared 32x32 multiplier; only the low 64 product bits are kept overall.
   always_comb begin
      case (cmd.mul_sel)
         MUL_LL: begin
            mul_a = state_ff[HALF_WIDTH-1:0];
            mul_b = OUT_MULT[HALF_WIDTH-1:0];
         end
         MUL_HL: begin
            mul_a = state_ff[WORD_WIDTH-1:HALF_WIDTH];
            mul_b = OUT_MULT[HALF_WIDTH-1:0];
         end
         MUL_LH: begin
            mul_a = state_ff[HALF_WIDTH-1:0];
            mul_b = OUT_MULT[WORD_WIDTH-1:HALF_WIDTH];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign acc_sum = acc_ff + {prod_ff[HALF_WIDTH-1:0], {HALF_WIDTH{1'b0}}};

   // Generator state, product and accumulator.
   always_comb begin
      state_in = state_ff;
      if (cmd.seed_init) begin
         state_in = SEED_XOR;
      end else if (cmd.seed_load) begin
         state_in = SEED_XOR ^ csr_data;
      end else if (cmd.rng_step) begin
         state_in = xs3;
      end else if (cmd.state_from_prod) begin
         state_in = acc_sum;
      end

      prod_in = prod_ff;
      if (cmd.mul_en) begin
         prod_in = {{HALF_WIDTH{1'b0}}, mul_a} * {{HALF_WIDTH{1'b0}}, mul_b};
      end

      acc_in = acc_ff;
      if (cmd.acc_load) begin
         acc_in = prod_ff;
      end else if (cmd.acc_add) begin
         acc_in = acc_sum;
      end

      word_in = word_ff;
      if (cmd.word_from_prod) begin
         word_in = acc_sum;
      end
   end

   // Binary search: each step probes entry base + half - 1.
   assign probe    = base_ff + half_ff - COUNT_WIDTH'(1);
   assign rd_addr  = probe[INDEX_WIDTH-1:0];
   assign frac     = {1'b0, word_ff[WORD_WIDTH-1 -: FRACTION_BITS]};
   assign go_upper = !(frac < rd_data_ff);

   // When every probe goes to the upper half, the interval still holds the last
   // entry and the count past it, so the last entry gets one more probe.
   assign extra_probe = (half_ff == COUNT_WIDTH'(1)) && go_upper &&
                        (base_ff == COUNT_WIDTH'(TABLE_ENTRIES - 2));

   always_comb begin
      base_in = base_ff;
      half_in = half_ff;
      if (cmd.search_init) begin
         base_in = '0;
         half_in = COUNT_WIDTH'(TABLE_ENTRIES / 2);
      end else if (cmd.search_cmp) begin
         if (go_upper) begin
            base_in = base_ff + half_ff;
         end
         if (!extra_probe) begin
            half_in = half_ff >> 1;
         end
      end
   end

   assign status.search_last = (half_ff == COUNT_WIDTH'(1)) && !extra_probe;

   // Configuration registers other than the seed.
   always_comb begin
      trials_in  = trials_ff;
      reflect_in = reflect_ff;
      if (cmd.cfg_write) begin
         case (csr_index)
            CSR_TRIALS:  trials_in  = csr_data[SAMPLE_WIDTH-1:0];
            CSR_REFLECT: reflect_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Result formation with optional reflection, saturating at zero.
   assign count_ext = {{(SAMPLE_WIDTH-COUNT_WIDTH){1'b0}}, base_ff};

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.random_word = word_ff;
         if (!reflect_ff) begin
            rsp_in.sample = count_ext;
         end else if (count_ext > trials_ff) begin
            rsp_in.sample = '0;
         end else begin
            rsp_in.sample = trials_ff - count_ext;
         end
      end
   end

   assign rsp_data = rsp_ff;

   // Probability table with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.tbl_write) begin
         cdf_mem[req_data.entry_index] <= req_data.entry_value;
      end
      rd_data_ff <= cdf_mem[rd_addr];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      state_ff <= state_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      word_ff  <= word_in;
      base_ff  <= base_in;
      half_ff  <= half_in;
      rsp_ff   <= rsp_in;
   end

   // Configuration state with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         trials_ff  <= TRIALS_RESET;
         reflect_ff <= 1'b0;
      end else begin
         trials_ff  <= trials_in;
         reflect_ff <= reflect_in;
      end
   end

endmodule

// ----- design/bts_ctrl.sv -----
module bts_ctrl
   import bts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_cmd,
   output logic                     req_ready,
   input  logic                     csr_valid,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   output logic                     csr_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  dp_status_type            status,
   output dp_cmd_type               cmd
);

   typedef enum logic [9:0] {
      ST_INIT     = 10'b00_0000_0001,
      ST_IDLE     = 10'b00_0000_0010,
      ST_STEP     = 10'b00_0000_0100,
      ST_MUL0     = 10'b00_0000_1000,
      ST_MUL1     = 10'b00_0001_0000,
      ST_MUL2     = 10'b00_0010_0000,
      ST_FINISH   = 10'b00_0100_0000,
      ST_SRCH_RD  = 10'b00_1000_0000,
      ST_SRCH_CMP = 10'b01_0000_0000,
      ST_OUT      = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      reseed_ff, reseed_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_xfer, csr_xfer, rsp_free;

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_xfer  = req_valid && req_ready;
   assign csr_xfer  = csr_valid && csr_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Sequencer: next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      reseed_in = reseed_ff;
      cmd       = '0;
      cmd.mul_sel = MUL_LL;
      case (state_ff)
         ST_INIT: begin
            cmd.seed_init = 1'b1;
            reseed_in     = 1'b1;
            state_in      = ST_STEP;
         end
         ST_IDLE: begin
            if (csr_xfer) begin
               cmd.cfg_write = 1'b1;
               if (csr_index == CSR_SEED) begin
                  cmd.seed_load = 1'b1;
                  reseed_in     = 1'b1;
                  state_in      = ST_STEP;
               end
            end else if (req_xfer) begin
               if (req_cmd == CMD_DRAW) begin
                  reseed_in = 1'b0;
                  state_in  = ST_STEP;
               end else begin
                  cmd.tbl_write = 1'b1;
               end
            end
         end
         ST_STEP: begin
            cmd.rng_step = 1'b1;
            state_in     = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LL;
            state_in    = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_HL;
            cmd.acc_load = 1'b1;
            state_in     = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LH;
            cmd.acc_add = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (reseed_ff) begin
               cmd.state_from_prod = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               cmd.word_from_prod = 1'b1;
               cmd.search_init    = 1'b1;
               state_in           = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            cmd.search_cmp = 1'b1;
            state_in = status.search_last ? ST_OUT : ST_SRCH_RD;
         end
         ST_OUT: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // Output register valid: set on load, cleared on transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         reseed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reseed_ff    <= reseed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/binomial_table_sampler.sv -----
// Binomial sampler over a 64-entry cumulative probability table. A load item
// writes one 49-bit table entry (48 fraction bits) and gives no result, so loads
// can follow each other every cycle while no register write is pending. A draw
// item steps a 64-bit xorshift generator, forms its output with one shared 32x32
// multiplier from the low-low, high-low and low-high partial products, then
// binary-searches the table in six steps, each a synchronous table read and a
// compare, with a seventh step when every probe goes to the upper half. A draw
// keeps both ports not ready from its transfer until its result is loaded into
// the output register, also while the previous result still waits there. The
// result is the index of the first entry greater than the top 48 bits of the
// generator word (64 when none is), optionally reflected as trials minus index.
// Writing the seed register keeps both ports not ready while the generator is
// reseeded; after reset the generator seeds itself from zero before either port
// is ready. Table entries must be loaded before any draw reads them.
module binomial_table_sampler
   import bts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]    csr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer for handshakes, generator and search.
   bts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Generator, multiplier, table and result registers.
   bts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .req_data  (req_data),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench
   import bts_pkg::*;
();

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [VALUE_WIDTH-1:0] ONE_VALUE = VALUE_WIDTH'(1) << FRACTION_BITS;

   // One pending command for the table port, with an optional drain request.
   typedef struct {
      req_type payload;
      bit      drain_first;
   } queued_cmd_type;

   typedef enum logic [1:0] {
      STALL_NONE   = 2'd0,
      STALL_RANDOM = 2'd1,
      STALL_LONG   = 2'd2,
      STALL_SPARSE = 2'd3
   } stall_mode_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [WORD_WIDTH-1:0]    csr_data  = '0;

   // Shadow copy of the sampler state.
   logic [WORD_WIDTH-1:0]   xorshift_state;
   logic [SAMPLE_WIDTH-1:0] trials_shadow;
   logic                    reflect_shadow;
   logic [VALUE_WIDTH-1:0]  cdf_shadow [TABLE_ENTRIES];

   queued_cmd_type sampler_cmds[$];
   rsp_type        predicted_samples[$];
   bit             cmd_on_port = 1'b0;
   int             gap_left    = 0;
   int             burst_left  = 1;
   int             stall_left  = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   int             mismatch_count = 0;
   int             cycle_count    = 0;

   binomial_table_sampler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Step the xorshift generator and return its multiplied output word.
   function automatic logic [WORD_WIDTH-1:0] xorshift_next();
      logic [WORD_WIDTH-1:0] s;
      s = xorshift_state;
      s = s ^ (s >> SHIFT_A);
      s = s ^ (s << SHIFT_B);
      s = s ^ (s >> SHIFT_C);
      xorshift_state = s;
      return s * OUT_MULT;
   endfunction

   function automatic void reseed_shadow(input logic [WORD_WIDTH-1:0] value);
      xorshift_state = SEED_XOR ^ value;
      xorshift_state = xorshift_next();
   endfunction

   function automatic void apply_csr_write(input logic [CSR_IDX_WIDTH-1:0] idx,
                                           input logic [WORD_WIDTH-1:0] value);
      case (idx)
         CSR_SEED:    reseed_shadow(value);
         CSR_TRIALS:  trials_shadow = value[SAMPLE_WIDTH-1:0];
         CSR_REFLECT: reflect_shadow = value[0];
         default: ;
      endcase
   endfunction

   // Apply one accepted command: a load updates the table, a draw predicts a sample.
   function automatic void apply_sampler_cmd(input req_type cmd);
      logic [WORD_WIDTH-1:0]    word;
      logic [FRACTION_BITS-1:0] frac;
      logic [SAMPLE_WIDTH:0]    count;
      rsp_type                  draw;
      int                       lo;
      int                       hi;
      int                       mid;
      if (cmd.cmd == CMD_LOAD) begin
         cdf_shadow[cmd.entry_index] = cmd.entry_value;
      end else begin
         word = xorshift_next();
         frac = word[WORD_WIDTH-1 -: FRACTION_BITS];
         lo = -1;
         hi = TABLE_ENTRIES;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if ({1'b0, frac} < cdf_shadow[mid]) hi = mid;
            else lo = mid;
         end
         count = (SAMPLE_WIDTH + 1)'(hi);
         // Reflection saturates at zero when the index exceeds the trial count.
         if (reflect_shadow) begin
            count = (count > {1'b0, trials_shadow}) ? '0 : {1'b0, trials_shadow} - count;
         end
         draw.sample      = count[SAMPLE_WIDTH-1:0];
         draw.random_word = word;
         predicted_samples = {predicted_samples, draw};
      end
   endfunction

   task automatic flag_mismatch(input string what, input logic [WORD_WIDTH-1:0] exp_v,
                                input logic [WORD_WIDTH-1:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s: expected %0h, got %0h", what, exp_v, got_v);
      end
   endtask

   task automatic push_load(input int idx, input logic [VALUE_WIDTH-1:0] value,
                            input bit drain);
      queued_cmd_type c;
      c.payload.cmd         = CMD_LOAD;
      c.payload.entry_index = INDEX_WIDTH'(idx);
      c.payload.entry_value = value;
      c.drain_first         = drain;
      sampler_cmds = {sampler_cmds, c};
   endtask

   // The index and value fields of a draw are don't-care, so they carry noise.
   task automatic push_draw(input bit drain);
      queued_cmd_type c;
      c.payload.cmd         = CMD_DRAW;
      c.payload.entry_index = INDEX_WIDTH'($urandom_range(0, TABLE_ENTRIES - 1));
      c.payload.entry_value = VALUE_WIDTH'({$urandom, $urandom});
      c.drain_first         = drain;
      sampler_cmds = {sampler_cmds, c};
   endtask

   function automatic logic [VALUE_WIDTH-1:0] random_entry_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ONE_VALUE;
         default: return {1'b0, 16'($urandom), 32'($urandom)};
      endcase
   endfunction

   // Load a whole monotone cumulative table, sometimes ending exactly at one.
   task automatic push_cdf_table();
      logic [VALUE_WIDTH-1:0] running;
      logic [VALUE_WIDTH-1:0] step;
      running = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         step = {6'd0, 11'($urandom_range(0, 2047)), 32'($urandom)};
         if ($urandom_range(0, 3) == 0) step = '0;
         running = running + step;
         if (running > ONE_VALUE) running = ONE_VALUE;
         if (i == TABLE_ENTRIES - 1 && $urandom_range(0, 1) == 1) running = ONE_VALUE;
         push_load(i, running, 1'b0);
      end
   endtask

   // Mostly draws over a full table, with loads and an occasional fresh table.
   task automatic push_random_batch(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 199) == 0) push_cdf_table();
         if ($urandom_range(0, 9) < 7) begin
            push_draw(n == count / 2);
         end else begin
            push_load($urandom_range(0, TABLE_ENTRIES - 1), random_entry_value(),
                      n == count / 2);
         end
      end
   endtask

   // One register write; the channel rests before the next write.
   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [WORD_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_csr_write(idx, value);
      @(posedge clock);
   endtask

   // Wait until every command is sent and every sample is back, then let loads settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (sampler_cmds.size() != 0 || cmd_on_port || predicted_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Command driver with random bursts and gaps.
   always @(posedge clock) begin
      queued_cmd_type nxt;
      logic           take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_sampler_cmd(req_data);
            cmd_on_port = 1'b0;
         end
         if (!cmd_on_port) begin
            take = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (sampler_cmds.size() != 0 &&
                         !(sampler_cmds[0].drain_first && predicted_samples.size() != 0)) begin
               take = 1'b1;
            end
            if (take) begin
               nxt = sampler_cmds.pop_front();
               req_data <= nxt.payload;
               cmd_on_port = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_valid <= take;
         end
      end
   end

   // Sample receiver with a stall pattern that changes at random intervals.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(40, 400);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            STALL_NONE:   rsp_ready <= 1'b1;
            STALL_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            STALL_LONG:   rsp_ready <= (stall_left % 16) < 3;
            default:      rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Compare each sample transfer with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_samples.size() == 0) begin
            flag_mismatch("unexpected sample", '0, WORD_WIDTH'(rsp_data.sample));
         end else begin
            want = predicted_samples.pop_front();
            if (rsp_data.sample !== want.sample) begin
               flag_mismatch("sample", WORD_WIDTH'(want.sample),
                             WORD_WIDTH'(rsp_data.sample));
            end
            if (rsp_data.random_word !== want.random_word) begin
               flag_mismatch("random_word", want.random_word, rsp_data.random_word);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      trials_shadow  = TRIALS_RESET;
      reflect_shadow = 1'b0;
      reseed_shadow('0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a normal table, then the search paths to 64 and to 0.
      push_cdf_table();
      repeat (3) push_draw(1'b0);
      push_load(31, '0, 1'b0);
      push_load(47, '0, 1'b0);
      push_load(55, '0, 1'b0);
      push_load(59, '0, 1'b0);
      push_load(61, '0, 1'b0);
      push_load(62, '0, 1'b0);
      push_load(63, '0, 1'b0);
      repeat (2) push_draw(1'b0);
      push_load(31, ONE_VALUE, 1'b0);
      push_load(15, ONE_VALUE, 1'b0);
      push_load(7, ONE_VALUE, 1'b0);
      push_load(3, ONE_VALUE, 1'b0);
      push_load(1, ONE_VALUE, 1'b0);
      push_load(0, ONE_VALUE, 1'b0);
      repeat (2) push_draw(1'b0);
      wait_idle();

      // Reflection against zero trials saturates every sample.
      write_csr(CSR_SEED, '1);
      write_csr(CSR_TRIALS, '0);
      write_csr(CSR_REFLECT, 64'd1);
      repeat (3) push_draw(1'b0);
      push_cdf_table();
      repeat (3) push_draw(1'b0);
      wait_idle();

      // Largest trial count with reflection.
      write_csr(CSR_SEED, '0);
      write_csr(CSR_TRIALS, 64'd65535);
      push_random_batch(350);
      wait_idle();

      // Trial counts near the table size, so reflection both subtracts and saturates.
      write_csr(CSR_SEED, {$urandom, $urandom});
      write_csr(CSR_TRIALS, 64'($urandom_range(0, 70)));
      push_cdf_table();
      push_random_batch(350);
      wait_idle();

      // Plain sampling without reflection.
      write_csr(CSR_SEED, {$urandom, $urandom});
      write_csr(CSR_TRIALS, 64'(TRIALS_RESET));
      write_csr(CSR_REFLECT, '0);
      push_random_batch(350);
      wait_idle();

      if (mismatch_count == 0 && predicted_samples.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
